// File: hdl/ltm_pkg.sv
// Types, constants and byte classification helpers for the literal text matcher.
package ltm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_CASE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHOLE_WORD = 3'd6;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_EOL  = 2'd1,
        MODE_EOF  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] text_byte;
    } t_in_item;

    typedef struct packed {
        logic [23:0] line_number;
        logic [15:0] start_column;
    } t_out_item;

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
    endfunction

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic byte_ok(input logic [7:0] t, input logic [7:0] p,
                                     input logic fold);
        return (t == p) || (fold && ((t == lower_of(p)) || (t == upper_of(p))));
    endfunction

endpackage

// File: hdl/literal_text_matcher.sv
// Top level of the literal text matcher: window, counters, compare and result register.
//
// Searches a byte stream for a configured literal of 1 to PATTERN_MAX bytes and reports each
// match with its line number and start column. One item is taken every clock cycle unless a
// result not yet taken stalls it: the item is registered, then a single pass of parallel byte
// compares across the shift window decides the match and updates the column and line counters.
// A match is reported while the item that follows it is processed, since whole-word mode needs
// the next byte; the last match of a stream is held until another item (end of line or end of
// file) arrives. The user must write configuration through the plain write port while the
// block is idle; the block itself does not enforce this.
module literal_text_matcher
    import ltm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    logic [7:0]  r_pat [PATTERN_MAX];
    logic [5:0]  r_len_cfg;
    logic        r_fold;
    logic        r_whole;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic [7:0]  r_window [PATTERN_MAX];
    logic [15:0] r_col;
    logic [23:0] r_line;
    logic        r_pending;

    logic [7:0]  n_window [PATTERN_MAX];
    logic [15:0] n_col;
    logic [23:0] n_line;
    logic        n_pending;
    logic        n_out_valid;
    t_out_item   n_out_item;

    logic        advance;
    logic [5:0]  len;
    logic [7:0]  pat_al [PATTERN_MAX];
    logic [7:0]  wn [PATTERN_MAX];
    logic [7:0]  prev_byte;
    logic        all_ok;
    logic        in_span;
    logic        prev_bad;
    logic        reject;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PATTERN_MAX; p++) begin
                r_pat[p] <= 8'd0;
            end
            r_len_cfg <= 6'd1;
            r_fold    <= 1'b0;
            r_whole   <= 1'b0;
        end else if (i_cfg_we) begin
            for (int p = 0; p < PATTERN_MAX; p++) begin
                if (i_cfg_index == CFG_INDEX_W'(p >> 3)) begin
                    r_pat[p] <= i_cfg_data[8*(p & 7) +: 8];
                end
            end
            case (i_cfg_index)
                CFG_LENGTH:     r_len_cfg <= i_cfg_data[5:0];
                CFG_FOLD_CASE:  r_fold    <= i_cfg_data[0];
                CFG_WHOLE_WORD: r_whole   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_len_cfg == 6'd0) begin
            len = 6'd1;
        end else if (r_len_cfg > 6'(PATTERN_MAX)) begin
            len = 6'(PATTERN_MAX);
        end else begin
            len = r_len_cfg;
        end
    end

    // align the pattern so that its last byte sits over the newest window byte
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pat_al[k] = 8'd0;
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (6'(j + k + 1) == len) begin
                    pat_al[k] = r_pat[j];
                end
            end
        end
    end

    always_comb begin
        wn[0] = r_in_item.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            wn[k] = r_window[k-1];
        end
        prev_byte = 8'd0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (6'(k + 1) == len) begin
                prev_byte = r_window[k];
            end
        end
        all_ok = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (6'(k) < len && !byte_ok(wn[k], pat_al[k], r_fold)) begin
                all_ok = 1'b0;
            end
        end
        in_span  = ({1'b0, r_col} + 17'd1) >= {11'd0, len};
        prev_bad = r_whole && (r_col >= {10'd0, len}) && is_word(prev_byte);
        reject   = r_whole && (r_in_item.mode == MODE_TEXT) && is_word(r_in_item.text_byte);
    end

    always_comb begin
        n_window    = r_window;
        n_col       = r_col;
        n_line      = r_line;
        n_pending   = r_pending;
        n_out_valid = 1'b0;
        n_out_item.line_number  = r_line;
        n_out_item.start_column = (r_col >= {10'd0, len}) ? r_col - {10'd0, len} : 16'd0;
        case (r_in_item.mode)
            MODE_TEXT: begin
                n_out_valid = r_pending && !reject;
                n_window    = wn;
                n_col       = (r_col == COL_MAX) ? r_col : r_col + 16'd1;
                n_pending   = in_span && all_ok && !prev_bad;
            end
            MODE_EOL: begin
                n_out_valid = r_pending;
                n_pending   = 1'b0;
                n_line      = (r_line == LINE_MAX) ? r_line : r_line + 24'd1;
                n_col       = 16'd0;
            end
            MODE_EOF: begin
                n_out_valid = r_pending;
                n_pending   = 1'b0;
                n_line      = 24'd1;
                n_col       = 16'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col       <= 16'd0;
            r_line      <= 24'd1;
            r_pending   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= n_out_valid;
                r_col       <= n_col;
                r_line      <= n_line;
                r_pending   <= n_pending;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_window <= n_window;
            if (n_out_valid) begin
                r_out_item <= n_out_item;
            end
        end
    end

endmodule

// File: bench/match_checker.sv
// Checker for the literal text matcher: follows the channels, predicts the matches and compares.
module match_checker
    import ltm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in_item               i_in_item,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out_item              i_out_item,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  pattern [0:31];
    logic [5:0]  length_code;
    logic        fold_case;
    logic        whole_word;

    logic [7:0]  history [0:32];
    int unsigned column;
    int unsigned line_no;
    bit          held_hit;

    t_out_item   due_matches [$];
    int          mismatches = 0;

    function automatic bit word_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
    endfunction

    function automatic bit byte_fits(input logic [7:0] t, input logic [7:0] p);
        logic [7:0] lo;
        logic [7:0] up;
        lo = (p >= 8'h41 && p <= 8'h5A) ? p + 8'd32 : p;
        up = (p >= 8'h61 && p <= 8'h7A) ? p - 8'd32 : p;
        return (t == p) || (fold_case && (t == lo || t == up));
    endfunction

    task automatic clear_model();
        for (int i = 0; i < 32; i++) pattern[i] = 8'h00;
        for (int i = 0; i <= 32; i++) history[i] = 8'h00;
        length_code = 6'd1;
        fold_case   = 1'b0;
        whole_word  = 1'b0;
        column      = 0;
        line_no     = 1;
        held_hit    = 1'b0;
    endtask

    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        int base;
        base = 0;
        case (idx)
            CFG_PAT_0_7:    base = 0;
            CFG_PAT_8_15:   base = 8;
            CFG_PAT_16_23:  base = 16;
            CFG_PAT_24_31:  base = 24;
            CFG_LENGTH:     length_code = data[5:0];
            CFG_FOLD_CASE:  fold_case = data[0];
            CFG_WHOLE_WORD: whole_word = data[0];
            default: ;
        endcase
        if (idx == CFG_PAT_0_7 || idx == CFG_PAT_8_15 ||
            idx == CFG_PAT_16_23 || idx == CFG_PAT_24_31) begin
            for (int b = 0; b < 8; b++) pattern[base + b] = data[8*b +: 8];
        end
    endtask

    task automatic scan_item(input t_in_item it);
        int unsigned span;
        int unsigned prior;
        bit          hit;
        t_out_item   found;
        if (!(it.mode == MODE_TEXT || it.mode == MODE_EOL || it.mode == MODE_EOF)) return;
        span = (length_code == 0) ? 1 : ((length_code > 32) ? 32 : length_code);

        // resolve the match held from the previous text byte
        if (held_hit) begin
            if (!(whole_word && it.mode == MODE_TEXT && word_byte(it.text_byte))) begin
                found.line_number  = line_no[23:0];
                found.start_column = (column >= span) ? 16'(column - span) : 16'd0;
                due_matches.push_back(found);
            end
            held_hit = 1'b0;
        end

        case (it.mode)
            MODE_TEXT: begin
                for (int i = 32; i > 0; i--) history[i] = history[i-1];
                history[0] = it.text_byte;
                prior = column;
                if (column < 32'hFFFF) column++;
                hit = (prior + 1 >= span);
                for (int i = 0; i < 32; i++) begin
                    if (i < span && !byte_fits(history[span-1-i], pattern[i])) hit = 1'b0;
                end
                if (hit && whole_word && prior >= span && word_byte(history[span])) hit = 1'b0;
                held_hit = hit;
            end
            MODE_EOL: begin
                if (line_no < 32'hFFFFFF) line_no++;
                column = 0;
            end
            default: begin
                line_no = 1;
                column  = 0;
            end
        endcase
    endtask

    initial clear_model();

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            clear_model();
            due_matches.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_matches.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected match, expected none, got line %0d column %0d",
                             $time, i_out_item.line_number, i_out_item.start_column);
                end else begin
                    want = due_matches.pop_front();
                    if (want !== i_out_item) mismatches++;
                    if (want.line_number !== i_out_item.line_number)
                        $display("%0t: line_number expected %0d, got %0d",
                                 $time, want.line_number, i_out_item.line_number);
                    if (want.start_column !== i_out_item.start_column)
                        $display("%0t: start_column expected %0d, got %0d",
                                 $time, want.start_column, i_out_item.start_column);
                end
            end
            if (i_cfg_we) load_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) scan_item(i_in_item);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= due_matches.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the literal text matcher bench: clock, reset, configuration, text stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ltm_pkg::*;

    localparam logic [1:0]  MODE_SPARE    = 2'd3;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 65;
    localparam logic [63:0] PATTERN_CHARS = "abXY_3 -";
    localparam logic [31:0] GAP_CHARS     = " _.q";

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_item;
    int                     mismatches;
    int                     outstanding;
    bit                     hold_start = 1'b0;

    logic [7:0]             pat_bytes [0:31];
    int unsigned            eff_len = 1;
    bit                     fold_now = 1'b0;

    literal_text_matcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    match_checker match_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        return ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) ? c ^ 8'h20 : c;
    endfunction

    function automatic logic [63:0] pattern_word(input int w);
        logic [63:0] word;
        for (int b = 0; b < 8; b++) word[8*b +: 8] = pat_bytes[8*w + b];
        return word;
    endfunction

    function automatic logic [7:0] filler_byte();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'($urandom_range(0, 255));
        if (r < 3) return GAP_CHARS[8*$urandom_range(0, 3) +: 8];
        c = pat_bytes[$urandom_range(0, eff_len - 1)];
        return (fold_now && $urandom_range(0, 1) == 1) ? flip_case(c) : c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_matcher(input logic [5:0] len_code, input logic fold,
                                   input logic ww);
        write_reg(CFG_PAT_0_7, pattern_word(0));
        write_reg(CFG_PAT_8_15, pattern_word(1));
        write_reg(CFG_PAT_16_23, pattern_word(2));
        write_reg(CFG_PAT_24_31, pattern_word(3));
        write_reg(CFG_LENGTH, 64'(len_code));
        write_reg(CFG_FOLD_CASE, 64'(fold));
        write_reg(CFG_WHOLE_WORD, 64'(ww));
        cfg_we   <= 1'b0;
        eff_len  = (len_code == 0) ? 1 : ((len_code > 32) ? 32 : len_code);
        fold_now = fold;
    endtask

    task automatic send(input logic [1:0] mode, input logic [7:0] data, input bit dense);
        t_in_item    it;
        int unsigned gap;
        it.mode      = t_mode'(mode);
        it.text_byte = data;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (!dense) begin
            gap = idle_span();
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send(MODE_TEXT, s[i], 1'b0);
    endtask

    // drain every expected match, then let the pipeline empty before reconfiguring
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int k);
        logic [5:0]  len_code;
        logic        fold;
        logic        ww;
        bit          dense;
        int unsigned r;
        int          sent;
        logic [7:0]  c;
        for (int i = 0; i < 32; i++)
            pat_bytes[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : PATTERN_CHARS[8*$urandom_range(0, 7) +: 8];
        fold  = $urandom_range(0, 1);
        ww    = $urandom_range(0, 1);
        dense = ($urandom_range(0, 3) == 0);
        case (k)
            0:       len_code = 6'd0;
            1:       len_code = 6'd1;
            2:       len_code = 6'd32;
            3:       len_code = 6'd63;
            default: len_code = 6'($urandom_range(1, 6));
        endcase
        if (k == 1) begin
            pat_bytes[0] = "a";
            ww = 1'b0;
        end
        program_matcher(len_code, fold, ww);
        if (k == 1) hold_start = 1'b1;

        sent = 0;
        while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                for (int i = 0; i < eff_len; i++) begin
                    c = pat_bytes[i];
                    if (fold && $urandom_range(0, 1) == 1) c = flip_case(c);
                    send(MODE_TEXT, c, dense);
                end
                sent += eff_len;
            end else if (r < 41) begin
                send(MODE_EOL, 8'($urandom_range(0, 255)), dense);
                sent++;
            end else if (r < 43) begin
                send(MODE_EOF, 8'($urandom_range(0, 255)), dense);
                sent++;
            end else if (r < 45) begin
                send(MODE_SPARE, 8'($urandom_range(0, 255)), dense);
            end else begin
                send(MODE_TEXT, filler_byte(), dense);
                sent++;
            end
        end
        settle();
    endtask

    initial begin : receiver
        int unsigned span;
        bit          hold_done;
        hold_done = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_start && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 12);
                repeat (span) @(posedge clk);
                out_ready <= 1'b0;
                repeat (idle_span() + 1) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i < 32; i++) pat_bytes[i] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: single zero byte pattern
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_TEXT, 8'hFF, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_SPARE, 8'h00, 1'b0);
        send(MODE_EOL, 8'h00, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b0);
        send(MODE_EOF, 8'h00, 1'b0);
        send(MODE_TEXT, 8'h00, 1'b0);
        settle();

        // case-folded whole-word search, unused pattern bytes all ones
        for (int i = 0; i < 32; i++) pat_bytes[i] = 8'hFF;
        pat_bytes[0] = "a";
        pat_bytes[1] = "B";
        pat_bytes[2] = "_";
        program_matcher(6'd3, 1'b1, 1'b1);
        send_string("zab_ Ab_!AB_x ab_");
        settle();

        for (int k = 0; k < RANDOM_PHASES; k++) run_random_phase(k);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
